// ===== rtl/core/rmq_pkg.sv =====
// shared constants and types for the rotation matrix to quaternion pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    localparam int N_ELEM        = 9;
    localparam int N_COMP        = 4;
    localparam int IN_TDATA_W    = ELEM_W * N_ELEM;
    localparam int OUT_TDATA_W   = ELEM_W * N_COMP;

    // per-stage advance and item valid, handed to each pipelined unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;
endpackage
`default_nettype wire

// ===== rtl/core/rmq_isqrt.sv =====
// pipelined integer square root, one root bit per register stage
// depends on rmq_pkg
`timescale 1ns / 1ps
`default_nettype none
module rmq_isqrt #(
    parameter int IW  = 32,
    parameter int SBW = 1,
    localparam int OW = (IW + 1) / 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rmq_pkg::t_stage_ctl i_ctl,
    input  wire logic [IW-1:0]      i_value,
    input  wire logic [SBW-1:0]     i_sb,
    output logic                    o_valid,
    output logic [OW-1:0]           o_root,
    output logic [SBW-1:0]          o_sb
);
    localparam int PW  = 2 * OW;
    localparam int RMW = OW + 2;

    logic           r_vld  [OW];
    logic [PW-1:0]  r_x    [OW];
    logic [RMW-1:0] r_rem  [OW];
    logic [OW-1:0]  r_root [OW];
    logic [SBW-1:0] r_sb   [OW];

    logic           p_vld  [OW];
    logic [PW-1:0]  p_x    [OW];
    logic [RMW-1:0] p_rem  [OW];
    logic [OW-1:0]  p_root [OW];
    logic [SBW-1:0] p_sb   [OW];

    assign p_vld[0]  = i_ctl.valid;
    assign p_x[0]    = PW'(i_value);
    assign p_rem[0]  = '0;
    assign p_root[0] = '0;
    assign p_sb[0]   = i_sb;

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic [RMW+1:0] wide;
        logic [RMW+1:0] trial;
        logic [RMW-1:0] n_rem;
        logic [OW-1:0]  n_root;

        if (k > 0) begin : g_link
            assign p_vld[k]  = r_vld[k-1];
            assign p_x[k]    = r_x[k-1];
            assign p_rem[k]  = r_rem[k-1];
            assign p_root[k] = r_root[k-1];
            assign p_sb[k]   = r_sb[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        always_comb begin
            wide  = {p_rem[k], p_x[k][PW-1 -: 2]};
            trial = (RMW+2)'({p_root[k], 2'b01});
            if (wide >= trial) begin
                n_rem  = RMW'(wide - trial);
                n_root = {p_root[k][OW-2:0], 1'b1};
            end else begin
                n_rem  = RMW'(wide);
                n_root = {p_root[k][OW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[k] <= p_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x[k]    <= p_x[k] << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_sb[k]   <= p_sb[k];
            end
        end
    end

    assign o_valid = r_vld[OW-1];
    assign o_root  = r_root[OW-1];
    assign o_sb    = r_sb[OW-1];
endmodule
`default_nettype wire

// ===== rtl/core/rmq_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
// depends on rmq_pkg
`timescale 1ns / 1ps
`default_nettype none
module rmq_div #(
    parameter int DW  = 31,
    parameter int NW  = 17,
    parameter int QB  = 16,
    parameter int SBW = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rmq_pkg::t_stage_ctl i_ctl,
    input  wire logic [DW-1:0]      i_dividend,
    input  wire logic [NW-1:0]      i_divisor,
    input  wire logic [SBW-1:0]     i_sb,
    output logic                    o_valid,
    output logic [QB-1:0]           o_quot,
    output logic [SBW-1:0]          o_sb
);
    logic           r_vld [QB];
    logic [NW-1:0]  r_rem [QB];
    logic [QB-1:0]  r_low [QB];
    logic [QB-1:0]  r_q   [QB];
    logic [NW-1:0]  r_d   [QB];
    logic [SBW-1:0] r_sb  [QB];

    logic           p_vld [QB];
    logic [NW-1:0]  p_rem [QB];
    logic [QB-1:0]  p_low [QB];
    logic [QB-1:0]  p_q   [QB];
    logic [NW-1:0]  p_d   [QB];
    logic [SBW-1:0] p_sb  [QB];

    // upper dividend part is below the divisor, so only QB quotient bits remain
    assign p_vld[0] = i_ctl.valid;
    assign p_rem[0] = NW'(i_dividend[DW-1:QB]);
    assign p_low[0] = i_dividend[QB-1:0];
    assign p_q[0]   = '0;
    assign p_d[0]   = i_divisor;
    assign p_sb[0]  = i_sb;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [NW:0]   wide;
        logic [NW-1:0] n_rem;
        logic [QB-1:0] n_q;

        if (k > 0) begin : g_link
            assign p_vld[k] = r_vld[k-1];
            assign p_rem[k] = r_rem[k-1];
            assign p_low[k] = r_low[k-1];
            assign p_q[k]   = r_q[k-1];
            assign p_d[k]   = r_d[k-1];
            assign p_sb[k]  = r_sb[k-1];
        end

        always_comb begin
            wide = {p_rem[k], p_low[k][QB-1]};
            if (wide >= {1'b0, p_d[k]}) begin
                n_rem = NW'(wide - {1'b0, p_d[k]});
                n_q   = {p_q[k][QB-2:0], 1'b1};
            end else begin
                n_rem = NW'(wide);
                n_q   = {p_q[k][QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[k] <= p_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= p_low[k] << 1;
                r_q[k]   <= n_q;
                r_d[k]   <= p_d[k];
                r_sb[k]  <= p_sb[k];
            end
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_quot  = r_q[QB-1];
    assign o_sb    = r_sb[QB-1];
endmodule
`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// top level: rotation matrix to normalized quaternion, fully pipelined
// depends on rmq_pkg, rmq_isqrt, rmq_div
`timescale 1ns / 1ps
`default_nettype none
// Converts the 3x3 rotation part of a column-major 4x4 matrix (entries 0,1,2,
// 4,5,6,8,9,10, signed Q(FRAC_BITS)) into a unit quaternion w,x,y,z in the same
// format. One matrix can be taken every cycle while the output is not stalled;
// results leave in input order. The magnitude width is SW = (max(FRAC_BITS,17)
// + 1 + FRAC_BITS + 1) / 2. Most of the pipeline depth comes from the two
// bit-per-stage square root pipelines (four magnitudes, then the norm) and the
// bit-per-stage dividers that normalize. The whole pipeline advances together
// and holds when the output register is full and not taken, so nothing is
// dropped. The largest magnitude keeps a positive sign (ties go to w, then x,
// y, z); a zero sign operand counts as negative. Outputs saturate to 16 bits.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // elem_0, elem_1, elem_2, elem_4, elem_5, elem_6, elem_8, elem_9, elem_10
    input  wire logic [rmq_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [rmq_pkg::OUT_TDATA_W-1:0]       o_m_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready
);
    localparam int F   = FRAC_BITS;
    localparam int EW  = rmq_pkg::ELEM_W;
    localparam int NC  = rmq_pkg::N_COMP;
    localparam int RU  = ((F > 17) ? F : 17) + 1;   // clamped radicand width
    localparam int RS  = RU + 2;                    // signed radicand width
    localparam int VW  = RU + F;                    // radicand scaled by one
    localparam int SW  = (VW + 1) / 2;              // magnitude width
    localparam int QW  = 2 * SW + 2;                // sum of squares width
    localparam int NW  = SW + 1;                    // norm width
    localparam int DW  = SW + F + 1;                // dividend width
    localparam int QB  = F + 2;                     // quotient width
    localparam int QX  = QB + EW;
    localparam logic [EW-1:0] ONE_SAT = (F >= EW - 1) ? {1'b0, {(EW-1){1'b1}}}
                                                      : EW'(1 << F);

    // global advance: move when the output register is free or being drained
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- stage 0: radicands and sign tests ----------------
    logic signed [EW-1:0] m [9];
    for (genvar j = 0; j < 9; j++) begin : g_unpack
        assign m[j] = i_s_tdata[EW*j +: EW];
    end
    // m[0..8] are entries 0,1,2,4,5,6,8,9,10

    logic signed [RS-1:0] c_rad [NC];
    logic [RU-1:0]        n0_rad [NC];
    logic [5:0]           n0_pos;
    logic signed [EW:0]   c_t [6];

    always_comb begin
        c_rad[0] = (RS'(1) <<< F) + RS'(m[0]) + RS'(m[4]) + RS'(m[8]);
        c_rad[1] = (RS'(1) <<< F) + RS'(m[0]) - RS'(m[4]) - RS'(m[8]);
        c_rad[2] = (RS'(1) <<< F) - RS'(m[0]) + RS'(m[4]) - RS'(m[8]);
        c_rad[3] = (RS'(1) <<< F) - RS'(m[0]) - RS'(m[4]) + RS'(m[8]);
        for (int i = 0; i < NC; i++) begin
            n0_rad[i] = c_rad[i][RS-1] ? '0 : c_rad[i][RU-1:0];
        end
        c_t[0] = (EW+1)'(m[5]) - (EW+1)'(m[7]);   // m6 - m9
        c_t[1] = (EW+1)'(m[6]) - (EW+1)'(m[2]);   // m8 - m2
        c_t[2] = (EW+1)'(m[1]) - (EW+1)'(m[3]);   // m1 - m4
        c_t[3] = (EW+1)'(m[1]) + (EW+1)'(m[3]);   // m1 + m4
        c_t[4] = (EW+1)'(m[6]) + (EW+1)'(m[2]);   // m8 + m2
        c_t[5] = (EW+1)'(m[5]) + (EW+1)'(m[7]);   // m6 + m9
        for (int i = 0; i < 6; i++) begin
            n0_pos[i] = !c_t[i][EW] && (|c_t[i]);
        end
    end

    logic          r0_vld;
    logic [RU-1:0] r0_rad [NC];
    logic [5:0]    r0_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_rad <= n0_rad;
            r0_pos <= n0_pos;
        end
    end

    // ---------------- four magnitude square roots ----------------
    rmq_pkg::t_stage_ctl ctl_s;
    assign ctl_s = '{en: en, valid: r0_vld};

    logic [SW-1:0] s_root [NC];
    logic [5:0]    s_pos;
    logic          s_vld;

    for (genvar i = 0; i < NC; i++) begin : g_mag
        logic          vld_i;
        logic [5:0]    sb_i;
        rmq_isqrt #(.IW(VW), .SBW(6)) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_s),
            .i_value ({r0_rad[i], {F{1'b0}}}),
            .i_sb    (r0_pos),
            .o_valid (vld_i),
            .o_root  (s_root[i]),
            .o_sb    (sb_i)
        );
        if (i == 0) begin : g_side
            assign s_vld = vld_i;
            assign s_pos = sb_i;
        end
    end

    // ---------------- stage 1: pick largest, signs, squares ----------------
    // sign bit set means the component is negated
    logic [1:0]    c_big;
    logic [NC-1:0] n1_neg;

    always_comb begin
        c_big = 2'd0;
        for (int i = 1; i < NC; i++) begin
            if (s_root[i] > s_root[c_big]) begin
                c_big = 2'(i);
            end
        end
        unique case (c_big)
            2'd0:    n1_neg = {!s_pos[2], !s_pos[1], !s_pos[0], 1'b0};
            2'd1:    n1_neg = {!s_pos[4], !s_pos[3], 1'b0, !s_pos[0]};
            2'd2:    n1_neg = {!s_pos[5], 1'b0, !s_pos[3], !s_pos[1]};
            default: n1_neg = {1'b0, !s_pos[5], !s_pos[4], !s_pos[2]};
        endcase
    end

    logic            r1_vld;
    logic [SW-1:0]   r1_s   [NC];
    logic [2*SW-1:0] r1_sq  [NC];
    logic [NC-1:0]   r1_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NC; i++) begin
                r1_s[i]  <= s_root[i];
                r1_sq[i] <= (2*SW)'(s_root[i]) * (2*SW)'(s_root[i]);
            end
            r1_neg <= n1_neg;
        end
    end

    // ---------------- stage 2: sum of squares ----------------
    logic          r2_vld;
    logic [QW-1:0] r2_sum;
    logic [SW-1:0] r2_s [NC];
    logic [NC-1:0] r2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sum <= QW'(r1_sq[0]) + QW'(r1_sq[1]) + QW'(r1_sq[2]) + QW'(r1_sq[3]);
            r2_s   <= r1_s;
            r2_neg <= r1_neg;
        end
    end

    // ---------------- norm square root ----------------
    localparam int NSB = NC + NC * SW;
    rmq_pkg::t_stage_ctl ctl_n;
    assign ctl_n = '{en: en, valid: r2_vld};

    logic           n_vld;
    logic [NW-1:0]  n_root;
    logic [NSB-1:0] n_sb_in;
    logic [NSB-1:0] n_sb_out;

    always_comb begin
        n_sb_in[NC-1:0] = r2_neg;
        for (int i = 0; i < NC; i++) begin
            n_sb_in[NC + SW*i +: SW] = r2_s[i];
        end
    end

    rmq_isqrt #(.IW(QW), .SBW(NSB)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_n),
        .i_value (r2_sum),
        .i_sb    (n_sb_in),
        .o_valid (n_vld),
        .o_root  (n_root),
        .o_sb    (n_sb_out)
    );

    // ---------------- stage 3: rounded dividends ----------------
    logic          r3_vld;
    logic [DW-1:0] r3_div [NC];
    logic [NW-1:0] r3_n;
    logic [NC-1:0] r3_neg;
    logic          r3_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NC; i++) begin
                // add half the norm so the quotient rounds half up
                r3_div[i] <= (DW'(n_sb_out[NC + SW*i +: SW]) << F) + DW'(n_root >> 1);
            end
            r3_n   <= n_root;
            r3_neg <= n_sb_out[NC-1:0];
            r3_nz  <= |n_root;
        end
    end

    // ---------------- normalizing dividers ----------------
    rmq_pkg::t_stage_ctl ctl_d;
    assign ctl_d = '{en: en, valid: r3_vld};

    logic [QB-1:0] d_q [NC];
    logic [NC:0]   d_sb;
    logic          d_vld;

    for (genvar i = 0; i < NC; i++) begin : g_div
        logic        vld_i;
        logic [NC:0] sb_i;
        rmq_div #(.DW(DW), .NW(NW), .QB(QB), .SBW(NC+1)) u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl_d),
            .i_dividend (r3_div[i]),
            .i_divisor  (r3_n),
            .i_sb       ({r3_nz, r3_neg}),
            .o_valid    (vld_i),
            .o_quot     (d_q[i]),
            .o_sb       (sb_i)
        );
        if (i == 0) begin : g_side
            assign d_vld = vld_i;
            assign d_sb  = sb_i;
        end
    end

    // ---------------- output register: sign, saturate ----------------
    logic [rmq_pkg::OUT_TDATA_W-1:0] n_out;
    logic [QX-1:0]                   c_qx [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            c_qx[i] = QX'(d_q[i]);
            if (!d_sb[NC]) begin
                // zero norm: identity quaternion
                n_out[EW*i +: EW] = (i == 0) ? ONE_SAT : '0;
            end else if (!d_sb[i]) begin
                n_out[EW*i +: EW] = (c_qx[i] > QX'(32767)) ? {1'b0, {(EW-1){1'b1}}}
                                                           : EW'(c_qx[i]);
            end else begin
                n_out[EW*i +: EW] = (c_qx[i] > QX'(32768)) ? {1'b1, {(EW-1){1'b0}}}
                                                           : EW'(-c_qx[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (en) begin
            o_m_tvalid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_tdata <= n_out;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rmq_checker.sv =====
// port-level checker for the rotation matrix to quaternion block, with bind
// depends on rmq_pkg and rotation_matrix_to_quaternion
`timescale 1ns / 1ps
`default_nettype none
module rmq_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic [rmq_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready
);
    // input side is open whenever the output side is not stalled
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input not ready while output free");

    // a stalled output holds the whole pipeline, so input is refused
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken during output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result present right after reset");

    // a stalled result is neither dropped nor changed
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
`default_nettype wire

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
// testbench for rotation_matrix_to_quaternion: directed table then random matrices,
// each checked against a typed-in answer or a behavioral predictor of the fixed-point quaternion conversion
// depends on rmq_pkg and the rotation_matrix_to_quaternion rtl
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_tb;
    localparam int FRAC        = rmq_pkg::FRAC_BITS_DEF;
    localparam int IN_TDATA_W  = rmq_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = rmq_pkg::OUT_TDATA_W;
    localparam int LATENCY     = 54;
    localparam int WDOG        = 4000;
    localparam int N_RAND      = 2000;

    typedef logic signed [15:0] t_elem;
    typedef struct packed {
        t_elem z;
        t_elem y;
        t_elem x;
        t_elem w;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0] i_s_tdata = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;

    always #6 i_clk = ~i_clk;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tdata(i_s_tdata), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .o_m_tdata(o_m_tdata), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready)
    );

    t_quat quat_fifo[$];
    int errors = 0;
    int idle_cycles = 0;
    bit quiet_phase = 0;   // long stretch with no idling on either side

    // bitwise integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag_of(input longint r);
        if (r < 0) r = 0;
        return int_sqrt(longint'(r) << FRAC);
    endfunction

    function automatic int sign_of(input longint v);
        return (v > 0) ? 1 : -1;
    endfunction

    function automatic t_elem sat16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_elem'(v);
    endfunction

    // matrix entries in tdata order: 0,1,2,4,5,6,8,9,10
    function automatic t_quat predict_quat(input logic [IN_TDATA_W-1:0] d);
        longint m[9];
        longint one;
        longint unsigned s[4];
        int sg[4];
        int big;
        longint unsigned sum, nrm, q;
        t_elem c[4];
        t_quat r;
        for (int i = 0; i < 9; i++) m[i] = longint'(t_elem'(d[16*i +: 16]));
        one = longint'(1) << FRAC;
        s[0] = mag_of(one + m[0] + m[4] + m[8]);
        s[1] = mag_of(one + m[0] - m[4] - m[8]);
        s[2] = mag_of(one - m[0] + m[4] - m[8]);
        s[3] = mag_of(one - m[0] - m[4] + m[8]);
        big = 0;
        for (int i = 1; i < 4; i++) if (s[i] > s[big]) big = i;
        sg = '{1, 1, 1, 1};
        // m1=m[1] m2=m[2] m4=m[3] m6=m[5] m8=m[6] m9=m[7]
        case (big)
            0: begin
                sg[1] = sign_of(m[5] - m[7]);
                sg[2] = sign_of(m[6] - m[2]);
                sg[3] = sign_of(m[1] - m[3]);
            end
            1: begin
                sg[0] = sign_of(m[5] - m[7]);
                sg[2] = sign_of(m[1] + m[3]);
                sg[3] = sign_of(m[6] + m[2]);
            end
            2: begin
                sg[0] = sign_of(m[6] - m[2]);
                sg[1] = sign_of(m[1] + m[3]);
                sg[3] = sign_of(m[5] + m[7]);
            end
            default: begin
                sg[0] = sign_of(m[1] - m[3]);
                sg[1] = sign_of(m[6] + m[2]);
                sg[2] = sign_of(m[5] + m[7]);
            end
        endcase
        sum = 0;
        for (int i = 0; i < 4; i++) sum += s[i] * s[i];
        nrm = int_sqrt(sum);
        if (nrm == 0) begin
            r.w = sat16(one);
            r.x = '0;
            r.y = '0;
            r.z = '0;
            return r;
        end
        for (int i = 0; i < 4; i++) begin
            q = ((s[i] << FRAC) + (nrm >> 1)) / nrm;
            c[i] = sat16(sg[i] > 0 ? longint'(q) : -longint'(q));
        end
        r.w = c[0];
        r.x = c[1];
        r.y = c[2];
        r.z = c[3];
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_matrix(input t_elem e[9]);
        logic [IN_TDATA_W-1:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = e[i];
        return d;
    endfunction

    // directed rows: 0,1,2,4,5,6,8,9,10; rows with a typed-in answer set has_exp
    typedef struct {
        t_elem e[9];
        bit    has_exp;
        t_quat expq;
    } t_row;
    t_row dir_rows[$];

    task automatic add_row(input t_elem e[9], input bit he, input t_quat q);
        t_row r;
        r.e = e;
        r.has_exp = he;
        r.expq = q;
        dir_rows.push_back(r);
    endtask

    // one transfer into the block, with random idling at the falling edge
    task automatic send_matrix(input logic [IN_TDATA_W-1:0] d);
        while (!quiet_phase && $urandom_range(99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata <= d;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver side: random back pressure, always ready in the quiet phase
    always @(negedge i_clk) begin
        i_m_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 31);
    end

    // output check and watchdog at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (quat_fifo.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none got %h",
                             $realtime, o_m_tdata);
                    errors++;
                end else begin
                    t_quat exp_q, got_q;
                    exp_q = quat_fifo.pop_front();
                    got_q = o_m_tdata;
                    if (got_q.w !== exp_q.w)
                        $display("%0t: quat_w expected %0d got %0d", $realtime, exp_q.w, got_q.w);
                    if (got_q.x !== exp_q.x)
                        $display("%0t: quat_x expected %0d got %0d", $realtime, exp_q.x, got_q.x);
                    if (got_q.y !== exp_q.y)
                        $display("%0t: quat_y expected %0d got %0d", $realtime, exp_q.y, got_q.y);
                    if (got_q.z !== exp_q.z)
                        $display("%0t: quat_z expected %0d got %0d", $realtime, exp_q.z, got_q.z);
                    if (got_q !== exp_q) errors++;
                end
            end
            if (idle_cycles >= WDOG) begin
                $display("%0t: watchdog expired, %0d outstanding", $realtime, quat_fifo.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        t_elem e[9];
        t_quat q;
        logic [IN_TDATA_W-1:0] d;
        t_elem one_e, neg_e;
        int kind;
        one_e = t_elem'(1 << FRAC);
        neg_e = -one_e;

        // identity: w = 1.0
        e = '{one_e, 0, 0, 0, one_e, 0, 0, 0, one_e};
        q.w = one_e; q.x = 0; q.y = 0; q.z = 0;
        add_row(e, 1, q);
        // 180 deg about x: x largest, the other magnitudes are zero
        e = '{one_e, 0, 0, 0, neg_e, 0, 0, 0, neg_e};
        q.w = 0; q.x = one_e; q.y = 0; q.z = 0;
        add_row(e, 1, q);
        // 180 about y and z
        e = '{neg_e, 0, 0, 0, one_e, 0, 0, 0, neg_e};
        add_row(e, 0, q);
        e = '{neg_e, 0, 0, 0, neg_e, 0, 0, 0, one_e};
        add_row(e, 0, q);
        // all zero matrix: four-way tie, w wins
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        add_row(e, 0, q);
        // extremes of every field
        e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        add_row(e, 0, q);
        e = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        add_row(e, 0, q);
        e = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        add_row(e, 0, q);
        e = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        add_row(e, 0, q);
        e = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        add_row(e, 0, q);
        // 90 deg about x in both directions, then about y and about z
        e = '{one_e, 0, 0, 0, 0, one_e, 0, neg_e, 0};  add_row(e, 0, q);
        e = '{one_e, 0, 0, 0, 0, neg_e, 0, one_e, 0};  add_row(e, 0, q);
        e = '{0, 0, neg_e, 0, one_e, 0, one_e, 0, 0};  add_row(e, 0, q);
        e = '{0, one_e, 0, neg_e, 0, 0, 0, 0, one_e};  add_row(e, 0, q);
        // tie between x and y magnitudes
        e = '{0, one_e, 0, one_e, 0, 0, 0, 0, neg_e};  add_row(e, 0, q);
        // negative radicands clamped
        e = '{neg_e, 0, 0, 0, neg_e, 0, 0, 0, neg_e};  add_row(e, 0, q);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            d = pack_matrix(dir_rows[k].e);
            quat_fifo.push_back(dir_rows[k].has_exp ? dir_rows[k].expq : predict_quat(d));
            send_matrix(d);
        end

        for (int n = 0; n < N_RAND; n++) begin
            // a run with no idling at all, then back to random gaps
            quiet_phase = (n >= 600 && n < 900);
            // hold off once until the pipeline has drained
            if (n == 1200) begin
                i_s_tvalid <= 1'b0;
                while (quat_fifo.size() != 0) @(negedge i_clk);
            end
            kind = $urandom_range(9);
            if (kind < 6) begin
                // near-rotation: signed diagonal of about 1.0, small off-diagonals
                for (int i = 0; i < 9; i++) e[i] = t_elem'($urandom_range(4000) - 2000);
                e[0] = e[0] + ($urandom_range(1) ? one_e : neg_e);
                e[4] = e[4] + ($urandom_range(1) ? one_e : neg_e);
                e[8] = e[8] + ($urandom_range(1) ? one_e : neg_e);
            end else if (kind < 8) begin
                for (int i = 0; i < 9; i++) e[i] = t_elem'($urandom_range(32768) - 16384);
            end else begin
                for (int i = 0; i < 9; i++) e[i] = t_elem'($urandom);
            end
            d = pack_matrix(e);
            quat_fifo.push_back(predict_quat(d));
            send_matrix(d);
        end
        i_s_tvalid <= 1'b0;
        quiet_phase = 0;

        while (quat_fifo.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== rotation_matrix_to_quaternion.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_isqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion.sv
rtl/core/rmq_checker.sv
dv/rotation_matrix_to_quaternion_tb.sv
